/* design/prcd_pkg.sv */
// Shared types and constants of the planar run-length column decoder.
package prcd_pkg;

	localparam int ROW_W       = 10;
	localparam int COL_W       = 7;
	localparam int CFG_W       = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;

	localparam logic KIND_READ = 1'b1;

	localparam logic [2:0] ST_ACCEPT  = 3'd0;
	localparam logic [2:0] ST_COLUMN  = 3'd1;
	localparam logic [2:0] ST_IMAGE   = 3'd2;
	localparam logic [2:0] ST_OVERRUN = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;
	localparam logic [2:0] ST_ROW     = 3'd5;

	localparam logic [7:0] LITERAL_MIN   = 8'h08;
	localparam logic [7:0] CMD_COPY_PREV = 8'h00;
	localparam logic [7:0] CMD_REPEAT1   = 8'h01;
	localparam logic [7:0] CMD_REPEAT2   = 8'h02;
	localparam logic [7:0] CMD_XOR0      = 8'h03;
	localparam logic [7:0] CMD_SET_MASK  = 8'h06;
	localparam logic [7:0] CMD_ESCAPE    = 8'h07;
	localparam logic [7:0] MASK_ONES     = 8'hff;

	typedef struct packed {
		logic       kind;
		logic [7:0] stream_byte;
		logic [8:0] read_row;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] pixels;
		logic [6:0]  columns_done;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_ACCEPT    = 3'd0,
		OP_READ      = 3'd1,
		OP_FILL      = 3'd2,
		OP_PAIR      = 3'd3,
		OP_COPY_PREV = 3'd4,
		OP_COPY_XOR  = 3'd5
	} op_t;

	// one decoded request for the back end
	typedef struct packed {
		op_t        op;
		logic [8:0] count;
		logic [7:0] a;
		logic [7:0] b;
		logic [1:0] src;
		logic [8:0] row;
	} cmd_t;

endpackage

/* design/prcd_ram.sv */
// Generic simple dual-port RAM with registered read.
module prcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/prcd_queue.sv */
// Short request queue between parser and executor.
module prcd_queue import prcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic flush,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full      = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else if (flush) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

/* design/prcd_front.sv */
// Stream parser: turns each accepted request into one back-end command.
module prcd_front import prcd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     restart,
	input  logic     hold,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     push,
	output cmd_t     push_data
);

	typedef enum logic [4:0] {
		PH_CMD    = 5'b00001,
		PH_COUNT  = 5'b00010,
		PH_FIRST  = 5'b00100,
		PH_SECOND = 5'b01000,
		PH_ESCAPE = 5'b10000
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [2:0] pend_q, pend_d;
	logic [8:0] run_q, run_d;
	logic [7:0] first_q, first_d;
	logic [7:0] mask_q, mask_d;
	logic [7:0] byte_v;
	logic [8:0] count_v;
	cmd_t       cmd;

	assign in_ready  = !q_full && !hold;
	assign push      = in_valid && in_ready;
	assign push_data = cmd;

	always_comb begin
		phase_d   = phase_q;
		pend_d    = pend_q;
		run_d     = run_q;
		first_d   = first_q;
		mask_d    = mask_q;
		byte_v    = in_data.stream_byte;
		count_v   = 9'(byte_v) + 9'd1;
		cmd       = '0;
		cmd.op    = OP_ACCEPT;
		cmd.row   = in_data.read_row;
		cmd.count = 9'd1;
		if (in_data.kind == KIND_READ) begin
			cmd.op = OP_READ;
		end else begin
			unique case (phase_q)
				PH_COUNT: begin
					run_d = count_v;
					if (pend_q == CMD_REPEAT1[2:0] || pend_q == CMD_REPEAT2[2:0]) begin
						phase_d = PH_FIRST;
					end else begin
						phase_d   = PH_CMD;
						cmd.count = count_v;
						if (pend_q == CMD_COPY_PREV[2:0]) begin
							cmd.op = OP_COPY_PREV;
						end else begin
							cmd.op  = OP_COPY_XOR;
							cmd.src = 2'(pend_q - CMD_XOR0[2:0]);
							cmd.b   = mask_q;
							mask_d  = '0;
						end
					end
				end
				PH_FIRST: begin
					first_d = byte_v;
					if (pend_q == CMD_REPEAT2[2:0]) begin
						phase_d = PH_SECOND;
					end else begin
						phase_d   = PH_CMD;
						cmd.op    = OP_FILL;
						cmd.a     = byte_v;
						cmd.count = run_q;
					end
				end
				PH_SECOND: begin
					phase_d   = PH_CMD;
					cmd.op    = OP_PAIR;
					cmd.a     = first_q;
					cmd.b     = byte_v;
					cmd.count = run_q;
				end
				PH_ESCAPE: begin
					phase_d = PH_CMD;
					cmd.op  = OP_FILL;
					cmd.a   = byte_v;
				end
				PH_CMD: begin
					if (byte_v >= LITERAL_MIN) begin
						cmd.op = OP_FILL;
						cmd.a  = byte_v;
					end else if (byte_v == CMD_SET_MASK) begin
						mask_d = MASK_ONES;
					end else if (byte_v == CMD_ESCAPE) begin
						phase_d = PH_ESCAPE;
					end else begin
						pend_d  = byte_v[2:0];
						phase_d = PH_COUNT;
					end
				end
				default: phase_d = PH_CMD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			pend_q  <= '0;
			run_q   <= '0;
			first_q <= '0;
			mask_q  <= '0;
		end else if (restart) begin
			phase_q <= PH_CMD;
			pend_q  <= '0;
			run_q   <= '0;
			first_q <= '0;
			mask_q  <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
			run_q   <= run_d;
			first_q <= first_d;
			mask_q  <= mask_d;
		end
	end

endmodule

/* design/prcd_back.sv */
// Executor: plane store, row/plane/column tracking and result register.
module prcd_back import prcd_pkg::*; #(
	parameter int MAX_ROWS = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic [ROW_W-1:0] rows,
	input  logic [COL_W-1:0] cols,
	input  logic             q_valid,
	input  cmd_t             head,
	output logic             pop,
	output logic             clearing,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	localparam int RIW   = $clog2(MAX_ROWS);
	localparam int AW    = RIW + 1;
	localparam int DEPTH = 2 ** AW;
	localparam logic [1:0] PLANE_LAST = 2'd3;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_RUN  = 3'b010,
		B_READ = 3'b100
	} bstate_t;

	bstate_t          state_q;
	logic             bank_q;
	logic [ROW_W-1:0] row_pos_q;
	logic [1:0]       plane_q;
	logic [COL_W-1:0] col_q;
	logic             err_q;
	logic             done_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic [ROW_W-1:0] idx_q;
	logic [ROW_W-1:0] total_q;
	logic             pend_q;
	logic [ROW_W-1:0] wrow_q;
	logic             wodd_q;
	op_t              op_q;
	logic [7:0]       a_q;
	logic [7:0]       b_q;
	logic [1:0]       rplane_q;
	logic             rbank_q;
	logic             clr_busy_q;
	logic [AW-1:0]    clr_addr_q;

	logic [ROW_W-1:0] total;
	logic [ROW_W:0]   end_sum;
	logic [ROW_W:0]   adv_sum;
	logic [COL_W-1:0] col_inc;
	logic             out_free;
	logic             is_write;
	logic [3:0]       ram_we;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic [7:0]       wdata;
	logic [7:0]       rdata [4];
	logic [31:0]      pixels;

	function automatic out_item_t make_out(logic [2:0] st, logic [31:0] px,
			logic [COL_W-1:0] cd);
		out_item_t o;
		o.status       = st;
		o.pixels       = px;
		o.columns_done = cd;
		return o;
	endfunction

	assign total    = (head.op == OP_PAIR) ? {head.count, 1'b0} : {1'b0, head.count};
	assign end_sum  = {1'b0, row_pos_q} + {1'b0, total};
	assign adv_sum  = {1'b0, row_pos_q} + {1'b0, total_q};
	assign col_inc  = col_q + 1'b1;
	assign out_free = !out_valid_q || out_ready;
	assign is_write = (head.op == OP_FILL) || (head.op == OP_PAIR) ||
	                  (head.op == OP_COPY_PREV) || (head.op == OP_COPY_XOR);
	assign pop      = (state_q == B_IDLE) && q_valid && out_free && !clr_busy_q && !restart;
	assign clearing = clr_busy_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// read port: row reads hit the completed bank, runs use their source plane
	assign raddr = (state_q == B_IDLE) ? {~bank_q, RIW'(head.row)}
	                                   : {rbank_q, RIW'(row_pos_q + idx_q)};

	always_comb begin
		ram_we = '0;
		waddr  = {bank_q, RIW'(wrow_q)};
		unique case (op_q)
			OP_FILL:      wdata = a_q;
			OP_PAIR:      wdata = wodd_q ? b_q : a_q;
			OP_COPY_PREV: wdata = rdata[rplane_q] ^ b_q;
			OP_COPY_XOR:  wdata = rdata[rplane_q] ^ b_q;
			default:      wdata = a_q;
		endcase
		if (clr_busy_q) begin
			ram_we = '1;
			waddr  = clr_addr_q;
			wdata  = '0;
		end else if (state_q == B_RUN && pend_q) begin
			ram_we[plane_q] = 1'b1;
		end
	end

	// planar to chunky: pixel k takes bit 7-k of each plane
	always_comb begin
		pixels = '0;
		for (int k = 0; k < 8; k++) begin
			for (int p = 0; p < 4; p++) begin
				pixels[28 - 4*k + p] = rdata[p][7 - k];
			end
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_plane
		prcd_ram #(
			.WIDTH (8),
			.DEPTH (DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (ram_we[g]),
			.waddr (waddr),
			.wdata (wdata),
			.raddr (raddr),
			.rdata (rdata[g])
		);
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop && is_write) begin
			op_q     <= head.op;
			a_q      <= head.a;
			b_q      <= (head.op == OP_COPY_XOR || head.op == OP_PAIR) ? head.b : 8'h00;
			total_q  <= total;
			rplane_q <= (head.op == OP_COPY_XOR) ? head.src : plane_q;
			rbank_q  <= (head.op == OP_COPY_XOR) ? bank_q : ~bank_q;
		end
		if (state_q == B_RUN && idx_q != total_q) begin
			wrow_q <= row_pos_q + idx_q;
			wodd_q <= idx_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			bank_q      <= 1'b0;
			row_pos_q   <= '0;
			plane_q     <= '0;
			col_q       <= '0;
			err_q       <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (&clr_addr_q) clr_busy_q <= 1'b0;
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (restart) begin
				state_q     <= B_IDLE;
				bank_q      <= 1'b0;
				row_pos_q   <= '0;
				plane_q     <= '0;
				col_q       <= '0;
				err_q       <= 1'b0;
				done_q      <= 1'b0;
				out_valid_q <= 1'b0;
				pend_q      <= 1'b0;
			end else begin
				unique case (state_q)
					B_IDLE: begin
						if (pop) begin
							if (head.op == OP_READ) begin
								if ({1'b0, head.row} >= rows) begin
									out_valid_q <= 1'b1;
									out_q <= make_out(ST_IGNORED, '0, col_q);
								end else begin
									state_q <= B_READ;
								end
							end else if (err_q) begin
								out_valid_q <= 1'b1;
								out_q <= make_out(ST_OVERRUN, '0, col_q);
							end else if (done_q) begin
								out_valid_q <= 1'b1;
								out_q <= make_out(ST_IGNORED, '0, col_q);
							end else if (!is_write) begin
								out_valid_q <= 1'b1;
								out_q <= make_out(ST_ACCEPT, '0, col_q);
							end else if (end_sum > {1'b0, rows}) begin
								err_q       <= 1'b1;
								out_valid_q <= 1'b1;
								out_q <= make_out(ST_OVERRUN, '0, col_q);
							end else begin
								idx_q   <= '0;
								pend_q  <= 1'b0;
								state_q <= B_RUN;
							end
						end
					end
					B_READ: begin
						out_valid_q <= 1'b1;
						out_q       <= make_out(ST_ROW, pixels, col_q);
						state_q     <= B_IDLE;
					end
					B_RUN: begin
						if (idx_q != total_q) begin
							pend_q <= 1'b1;
							idx_q  <= idx_q + 1'b1;
						end else begin
							pend_q <= 1'b0;
						end
						if (idx_q == total_q && pend_q) begin
							state_q     <= B_IDLE;
							out_valid_q <= 1'b1;
							if (adv_sum < {1'b0, rows}) begin
								row_pos_q <= adv_sum[ROW_W-1:0];
								out_q <= make_out(ST_ACCEPT, '0, col_q);
							end else begin
								row_pos_q <= '0;
								if (plane_q != PLANE_LAST) begin
									plane_q <= plane_q + 1'b1;
									out_q <= make_out(ST_ACCEPT, '0, col_q);
								end else begin
									plane_q <= '0;
									bank_q  <= ~bank_q;
									col_q   <= col_inc;
									if (col_inc >= cols) begin
										done_q <= 1'b1;
										out_q <= make_out(ST_IMAGE, '0, col_inc);
									end else begin
										out_q <= make_out(ST_COLUMN, '0, col_inc);
									end
								end
							end
						end
					end
					default: state_q <= B_IDLE;
				endcase
			end
		end
	end

endmodule

/* design/planar_rle_column_decoder.sv */
// Top level of the planar run-length column decoder.
//
// Decodes a four-plane run-length image one 8-pixel column at a time and
// serves chunky row reads of the last completed column. A parser accepts one
// request per cycle, unless the queue is full or the store is being cleared,
// into a four-entry queue; the executor drains it. A two-byte repeat with a
// count of n writes 2n rows, and the single write port of the plane store
// sets the pace of runs. After reset the store is cleared, one address per
// cycle over all 2^(clog2(MAX_ROWS)+1) addresses (1024 at the default), and
// no request is taken until that pass ends. A register write starts a new
// image and keeps the store; index 0 is column_count, 1 is row_count, other
// indices are ignored. Writes are only legal while the block is idle. One
// result per request, in order.
module planar_rle_column_decoder import prcd_pkg::*; #(
	parameter int MAX_ROWS = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [COL_W-1:0] column_count_q;
	logic [ROW_W-1:0] row_count_q;
	logic [ROW_W-1:0] eff_rows;
	logic [COL_W-1:0] eff_cols;
	logic             restart;
	logic             push;
	cmd_t             push_data;
	logic             q_full;
	logic             q_valid;
	logic             pop;
	cmd_t             head;
	logic             clearing;

	// any write to a known register restarts the image
	assign restart = cfg_we && (cfg_index == CFG_COLUMN_COUNT || cfg_index == CFG_ROW_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= COL_W'(1);
			row_count_q    <= ROW_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == CFG_COLUMN_COUNT) column_count_q <= cfg_data[COL_W-1:0];
			if (cfg_index == CFG_ROW_COUNT) row_count_q <= cfg_data[ROW_W-1:0];
		end
	end

	// out-of-range settings are clamped
	always_comb begin
		if (row_count_q == '0) begin
			eff_rows = ROW_W'(1);
		end else if (32'(row_count_q) > MAX_ROWS) begin
			eff_rows = ROW_W'(MAX_ROWS);
		end else begin
			eff_rows = row_count_q;
		end
		eff_cols = (column_count_q == '0) ? COL_W'(1) : column_count_q;
	end

	prcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.hold      (clearing),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	prcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.flush     (restart),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (head)
	);

	prcd_back #(
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.rows      (eff_rows),
		.cols      (eff_cols),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
